FILE: sv/opm_pkg.sv
package opm_pkg;

   // Table geometry and hashing constants
   localparam int ProfileRows     = 20;
   localparam int ProfileCountDef = 20;
   localparam int LevelBits       = 5;
   localparam int WordBits        = 32;
   localparam int RecordWords     = 6;
   localparam int HashBits        = RecordWords * WordBits;
   localparam int HashBytes       = HashBits / 8;
   localparam int ByteCntBits     = $clog2(HashBytes);

   localparam logic [31:0] FnvOffset  = 32'd2166136261;
   localparam logic [31:0] FnvPrime   = 32'd16777619;
   localparam logic [31:0] RowFlags   = 32'h0000_0000;
   localparam logic [31:0] VersionRst = 32'd1;
   localparam logic [ByteCntBits-1:0] LastByte = ByteCntBits'(HashBytes - 1);

   // Configuration register indexes
   localparam logic CSR_INIT_LEVEL      = 1'b0;
   localparam logic CSR_PROFILE_VERSION = 1'b1;

   typedef enum logic [1:0] {
      OP_INIT     = 2'd0,
      OP_STAGE    = 2'd1,
      OP_APPLY    = 2'd2,
      OP_VALIDATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RC_OK        = 3'd0,
      RC_BAD_ARG   = 3'd1,
      RC_BAD_LEVEL = 3'd2,
      RC_MISMATCH  = 3'd3,
      RC_BUSY      = 3'd4
   } rc_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HASH,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [25:0] baud;
      logic [20:0] period;
      logic [12:0] train;
   } row_type;

   typedef struct packed {
      logic                 start;
      logic [31:0]          version;
      logic [LevelBits-1:0] level;
   } hash_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hash;
   } hash_res_type;

   function automatic row_type rom_row(input logic [LevelBits-1:0] idx);
      row_type r;
      r = '0;
      case (idx)
         5'd0:  r = '{26'd10000000, 21'd2000000, 13'd4096};
         5'd1:  r = '{26'd25000000, 21'd2000000, 13'd4096};
         5'd2:  r = '{26'd30000000, 21'd2000000, 13'd4096};
         5'd3:  r = '{26'd35000000, 21'd2000000, 13'd4096};
         5'd4:  r = '{26'd40000000, 21'd2000000, 13'd4096};
         5'd5:  r = '{26'd45000000, 21'd2000000, 13'd4096};
         5'd6:  r = '{26'd50000000, 21'd2000000, 13'd4096};
         5'd7:  r = '{26'd10000000, 21'd1000000, 13'd4096};
         5'd8:  r = '{26'd25000000, 21'd1000000, 13'd4096};
         5'd9:  r = '{26'd30000000, 21'd1000000, 13'd4096};
         5'd10: r = '{26'd35000000, 21'd1000000, 13'd4096};
         5'd11: r = '{26'd40000000, 21'd1000000, 13'd4096};
         5'd12: r = '{26'd45000000, 21'd1000000, 13'd4096};
         5'd13: r = '{26'd50000000, 21'd1000000, 13'd4096};
         5'd14: r = '{26'd30000000, 21'd100000,  13'd4096};
         5'd15: r = '{26'd35000000, 21'd100000,  13'd4096};
         5'd16: r = '{26'd40000000, 21'd100000,  13'd4096};
         5'd17: r = '{26'd45000000, 21'd100000,  13'd4096};
         5'd18: r = '{26'd50000000, 21'd100000,  13'd4096};
         5'd19: r = '{26'd1000000,  21'd2000000, 13'd4096};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Record as hashed: version in the low word, bytes leave LSB first
   function automatic logic [HashBits-1:0] pack_record(input logic [31:0] ver,
                                                       input logic [LevelBits-1:0] lvl);
      row_type r;
      r = rom_row(lvl);
      return {RowFlags, 32'(r.train), 32'(r.period), 32'(r.baud),
              32'(lvl), ver};
   endfunction

   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * FnvPrime;
   endfunction

   // Elaboration-time only: hash of a row, used for the reset value
   function automatic logic [31:0] fnv_row_hash(input logic [31:0] ver,
                                                input logic [LevelBits-1:0] lvl);
      logic [HashBits-1:0] rec;
      logic [31:0]         h;
      int                  i;
      rec = pack_record(ver, lvl);
      h   = FnvOffset;
      for (i = 0; i < HashBytes; i++) begin
         h = fnv_step(h, rec[8*i +: 8]);
      end
      return h;
   endfunction

   localparam logic [31:0] ResetHash = fnv_row_hash(VersionRst, '0);

endpackage

FILE: sv/opm_fnv_serial.sv
// Byte-serial FNV-1a over one profile record, one byte per cycle.
module opm_fnv_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  opm_pkg::hash_cmd_type cmd,
   output opm_pkg::hash_res_type res
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [opm_pkg::ByteCntBits-1:0]    cnt_ff, cnt_in;
   logic [opm_pkg::HashBits-1:0]       shift_ff, shift_in;
   logic [31:0]                        hash_ff, hash_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      hash_in  = hash_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = opm_pkg::pack_record(cmd.version, cmd.level);
         hash_in  = opm_pkg::FnvOffset;
      end else if (busy_ff) begin
         hash_in  = opm_pkg::fnv_step(hash_ff, shift_ff[7:0]);
         shift_in = shift_ff >> 8;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == opm_pkg::LastByte) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      hash_ff  <= hash_in;
   end

   assign res.done = done_ff;
   assign res.hash = hash_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("hash start while a record is in progress");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && $past(cnt_ff) == opm_pkg::LastByte))
      else $error("hash done without finishing the last byte");

endmodule

FILE: sv/operating_profile_manager_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  operation, level, record words, ring halted
// rsp       out        rsp_valid/rsp_stall  result code, success, profiles, counters
// csr       in         csr_wr_en            csr_index selects register, csr_wr_data
//
// One word at a time. Init, stage and a validate that passes the table check run
// through the FNV unit, which hashes 24 bytes, one per cycle, through a single
// 32x32 multiplier; apply and failing checks skip the hash and go straight to write.
// Reset is synchronous; level 0 is loaded in both profiles with its hash for
// version 1. A stalled rsp word holds; the next req word is still taken and
// worked on, and commits once the output register frees up.
module operating_profile_manager_core #(
   parameter int PROFILE_COUNT = opm_pkg::ProfileCountDef
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_level,
   input  logic [31:0] req_rec_version,
   input  logic [31:0] req_rec_baud_hz,
   input  logic [31:0] req_rec_period_ns,
   input  logic [31:0] req_rec_train_cycles,
   input  logic [31:0] req_rec_flags,
   input  logic [31:0] req_rec_hash,
   input  logic        req_ring_halted,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_code,
   output logic        rsp_success,
   output logic [4:0]  rsp_active_level,
   output logic [25:0] rsp_active_baud_hz,
   output logic [20:0] rsp_active_period_ns,
   output logic [12:0] rsp_active_train_cycles,
   output logic [31:0] rsp_active_hash,
   output logic [4:0]  rsp_staged_level,
   output logic [31:0] rsp_staged_hash,
   output logic [31:0] rsp_stages_done,
   output logic [31:0] rsp_applies_done,
   output logic [31:0] rsp_rejects_seen
);

   localparam int LB = opm_pkg::LevelBits;

   // Configuration registers
   logic [LB-1:0] init_lvl_ff;
   logic [31:0]   version_ff;

   // Sequencer and captured request word
   opm_pkg::state_type state_ff, state_in;
   opm_pkg::op_type    op_ff;
   opm_pkg::rc_type    rc_ff, rc_in;
   logic [LB-1:0]      hlvl_ff, hlvl_in;
   logic [31:0]        level_ff;
   logic [31:0]        rec_version_ff, rec_baud_ff, rec_period_ff;
   logic [31:0]        rec_train_ff, rec_flags_ff, rec_hash_ff;
   logic               ring_ff;

   // Profile state and counters
   logic [LB-1:0] active_lvl_ff, active_lvl_in;
   logic          active_present_ff, active_present_in;
   logic [31:0]   active_hash_ff, active_hash_in;
   logic [LB-1:0] staged_lvl_ff, staged_lvl_in;
   logic          staged_present_ff, staged_present_in;
   logic [31:0]   staged_hash_ff, staged_hash_in;
   logic [31:0]   stage_cnt_ff, stage_cnt_in;
   logic [31:0]   apply_cnt_ff, apply_cnt_in;
   logic [31:0]   reject_cnt_ff, reject_cnt_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   opm_pkg::rc_type rsp_rc_ff;
   logic [LB-1:0]   rsp_act_lvl_ff;
   logic [25:0]     rsp_act_baud_ff;
   logic [20:0]     rsp_act_period_ff;
   logic [12:0]     rsp_act_train_ff;
   logic [31:0]     rsp_act_hash_ff;
   logic [LB-1:0]   rsp_stg_lvl_ff;
   logic [31:0]     rsp_stg_hash_ff;
   logic [31:0]     rsp_stage_cnt_ff;
   logic [31:0]     rsp_apply_cnt_ff;
   logic [31:0]     rsp_reject_cnt_ff;

   opm_pkg::hash_cmd_type hash_cmd;
   opm_pkg::hash_res_type hash_res;

   logic              accept;
   logic              commit;
   logic [31:0]       eff_level;
   logic              level_good;
   opm_pkg::row_type  chk_row;
   logic              rec_differs;
   logic              need_hash;
   opm_pkg::rc_type   rc_final;
   opm_pkg::row_type  act_row;

   assign accept = req_valid && (state_ff == opm_pkg::ST_IDLE);
   assign commit = (state_ff == opm_pkg::ST_WRITE) && (!rsp_valid_ff || !rsp_stall);

   // Configuration writes; the host only writes while no word is in flight (the block does not enforce it)
   always_ff @(posedge clock) begin
      if (reset) begin
         init_lvl_ff <= '0;
         version_ff  <= opm_pkg::VersionRst;
      end else if (csr_wr_en) begin
         if (csr_index == opm_pkg::CSR_INIT_LEVEL) begin
            init_lvl_ff <= csr_wr_data[LB-1:0];
         end
         if (csr_index == opm_pkg::CSR_PROFILE_VERSION) begin
            version_ff <= csr_wr_data;
         end
      end
   end

   // Capture the request word on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff          <= opm_pkg::op_type'(req_operation);
         level_ff       <= req_level;
         rec_version_ff <= req_rec_version;
         rec_baud_ff    <= req_rec_baud_hz;
         rec_period_ff  <= req_rec_period_ns;
         rec_train_ff   <= req_rec_train_cycles;
         rec_flags_ff   <= req_rec_flags;
         rec_hash_ff    <= req_rec_hash;
         ring_ff        <= req_ring_halted;
      end
   end

   // Level check and table compare, in the cycle after accept.
   // Init works on the init level register; the other operations on the request level.
   assign eff_level  = (op_ff == opm_pkg::OP_INIT) ? 32'(init_lvl_ff) : level_ff;
   assign level_good = (eff_level < 32'(opm_pkg::ProfileRows)) &&
                       (eff_level < 32'(PROFILE_COUNT));
   assign chk_row    = opm_pkg::rom_row(eff_level[LB-1:0]);
   assign rec_differs = (rec_baud_ff   != 32'(chk_row.baud))   ||
                        (rec_period_ff != 32'(chk_row.period)) ||
                        (rec_train_ff  != 32'(chk_row.train))  ||
                        (rec_flags_ff  != opm_pkg::RowFlags);

   // The record hash of a validate that matches the table equals the row hash,
   // so every operation that hashes feeds the unit with the table row.
   assign hash_cmd.start   = (state_ff == opm_pkg::ST_CHECK) && need_hash;
   assign hash_cmd.version = version_ff;
   assign hash_cmd.level   = eff_level[LB-1:0];

   opm_fnv_serial u_fnv (
      .clock (clock),
      .reset (reset),
      .cmd   (hash_cmd),
      .res   (hash_res)
   );

   // Late result code: a validate that reached the hash may still mismatch
   assign rc_final = (op_ff == opm_pkg::OP_VALIDATE && rc_ff == opm_pkg::RC_OK &&
                      hash_res.hash != rec_hash_ff) ? opm_pkg::RC_MISMATCH : rc_ff;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      rc_in     = rc_ff;
      hlvl_in   = hlvl_ff;
      need_hash = 1'b0;
      unique case (state_ff)
         opm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = opm_pkg::ST_CHECK;
            end
         end
         opm_pkg::ST_CHECK: begin
            hlvl_in = eff_level[LB-1:0];
            unique case (op_ff)
               opm_pkg::OP_INIT, opm_pkg::OP_STAGE: begin
                  rc_in     = level_good ? opm_pkg::RC_OK : opm_pkg::RC_BAD_LEVEL;
                  need_hash = level_good;
               end
               opm_pkg::OP_APPLY: begin
                  rc_in = ring_ff ? opm_pkg::RC_OK : opm_pkg::RC_BUSY;
               end
               opm_pkg::OP_VALIDATE: begin
                  if (rec_version_ff != version_ff || !level_good || rec_differs) begin
                     rc_in = opm_pkg::RC_BAD_LEVEL;
                  end else begin
                     rc_in     = opm_pkg::RC_OK;
                     need_hash = 1'b1;
                  end
               end
               default: rc_in = opm_pkg::RC_BAD_LEVEL;
            endcase
            state_in = need_hash ? opm_pkg::ST_HASH : opm_pkg::ST_WRITE;
         end
         opm_pkg::ST_HASH: begin
            if (hash_res.done) begin
               state_in = opm_pkg::ST_WRITE;
            end
         end
         opm_pkg::ST_WRITE: begin
            if (commit) begin
               state_in = opm_pkg::ST_IDLE;
            end
         end
         default: state_in = opm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rc_ff   <= rc_in;
      hlvl_ff <= hlvl_in;
   end

   // Profile and counter updates, applied at commit
   always_comb begin
      active_lvl_in     = active_lvl_ff;
      active_present_in = active_present_ff;
      active_hash_in    = active_hash_ff;
      staged_lvl_in     = staged_lvl_ff;
      staged_present_in = staged_present_ff;
      staged_hash_in    = staged_hash_ff;
      stage_cnt_in      = stage_cnt_ff;
      apply_cnt_in      = apply_cnt_ff;
      reject_cnt_in     = reject_cnt_ff;
      if (commit) begin
         case (op_ff)
            opm_pkg::OP_INIT: begin
               // Drop both profiles and counters, then load the init level if it is valid
               stage_cnt_in  = '0;
               apply_cnt_in  = '0;
               reject_cnt_in = '0;
               if (rc_ff == opm_pkg::RC_OK) begin
                  active_present_in = 1'b1;
                  active_lvl_in     = hlvl_ff;
                  active_hash_in    = hash_res.hash;
                  staged_present_in = 1'b1;
                  staged_lvl_in     = hlvl_ff;
                  staged_hash_in    = hash_res.hash;
               end else begin
                  active_present_in = 1'b0;
                  active_lvl_in     = '0;
                  active_hash_in    = '0;
                  staged_present_in = 1'b0;
                  staged_lvl_in     = '0;
                  staged_hash_in    = '0;
               end
            end
            opm_pkg::OP_STAGE: begin
               if (rc_ff == opm_pkg::RC_OK) begin
                  staged_present_in = 1'b1;
                  staged_lvl_in     = hlvl_ff;
                  staged_hash_in    = hash_res.hash;
                  stage_cnt_in      = stage_cnt_ff + 32'd1;
               end else begin
                  reject_cnt_in = reject_cnt_ff + 32'd1;
               end
            end
            opm_pkg::OP_APPLY: begin
               // An empty staged profile copies over as empty
               if (rc_ff == opm_pkg::RC_OK) begin
                  active_present_in = staged_present_ff;
                  active_lvl_in     = staged_lvl_ff;
                  active_hash_in    = staged_hash_ff;
                  apply_cnt_in      = apply_cnt_ff + 32'd1;
               end else begin
                  reject_cnt_in = reject_cnt_ff + 32'd1;
               end
            end
            default: begin
               // Validate leaves all state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_lvl_ff     <= '0;
         active_present_ff <= 1'b1;
         active_hash_ff    <= opm_pkg::ResetHash;
         staged_lvl_ff     <= '0;
         staged_present_ff <= 1'b1;
         staged_hash_ff    <= opm_pkg::ResetHash;
         stage_cnt_ff      <= '0;
         apply_cnt_ff      <= '0;
         reject_cnt_ff     <= '0;
      end else begin
         active_lvl_ff     <= active_lvl_in;
         active_present_ff <= active_present_in;
         active_hash_ff    <= active_hash_in;
         staged_lvl_ff     <= staged_lvl_in;
         staged_present_ff <= staged_present_in;
         staged_hash_ff    <= staged_hash_in;
         stage_cnt_ff      <= stage_cnt_in;
         apply_cnt_ff      <= apply_cnt_in;
         reject_cnt_ff     <= reject_cnt_in;
      end
   end

   // Output register: load the post-operation view at commit, hold under stall
   assign act_row      = opm_pkg::rom_row(active_lvl_in);
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (commit) begin
         rsp_rc_ff         <= rc_final;
         rsp_act_lvl_ff    <= active_present_in ? active_lvl_in : '0;
         rsp_act_baud_ff   <= active_present_in ? act_row.baud : '0;
         rsp_act_period_ff <= active_present_in ? act_row.period : '0;
         rsp_act_train_ff  <= active_present_in ? act_row.train : '0;
         rsp_act_hash_ff   <= active_present_in ? active_hash_in : '0;
         rsp_stg_lvl_ff    <= staged_present_in ? staged_lvl_in : '0;
         rsp_stg_hash_ff   <= staged_present_in ? staged_hash_in : '0;
         rsp_stage_cnt_ff  <= stage_cnt_in;
         rsp_apply_cnt_ff  <= apply_cnt_in;
         rsp_reject_cnt_ff <= reject_cnt_in;
      end
   end

   assign req_stall               = (state_ff != opm_pkg::ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_code         = rsp_rc_ff;
   assign rsp_success             = (rsp_rc_ff == opm_pkg::RC_OK);
   assign rsp_active_level        = rsp_act_lvl_ff;
   assign rsp_active_baud_hz      = rsp_act_baud_ff;
   assign rsp_active_period_ns    = rsp_act_period_ff;
   assign rsp_active_train_cycles = rsp_act_train_ff;
   assign rsp_active_hash         = rsp_act_hash_ff;
   assign rsp_staged_level        = rsp_stg_lvl_ff;
   assign rsp_staged_hash         = rsp_stg_hash_ff;
   assign rsp_stages_done         = rsp_stage_cnt_ff;
   assign rsp_applies_done        = rsp_apply_cnt_ff;
   assign rsp_rejects_seen        = rsp_reject_cnt_ff;

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_res.done |-> (state_ff == opm_pkg::ST_HASH))
      else $error("hash result arrived outside the hash state");

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == opm_pkg::ST_WRITE))
      else $error("response word raised without a commit");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == opm_pkg::OP_INIT) |=>
         (rsp_stage_cnt_ff == '0 && rsp_apply_cnt_ff == '0 && rsp_reject_cnt_ff == '0))
      else $error("init did not clear the counters");

   a_stage_counts: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == opm_pkg::OP_STAGE && rc_ff == opm_pkg::RC_OK) |=>
         (stage_cnt_ff == $past(stage_cnt_ff) + 32'd1))
      else $error("successful stage not counted");

endmodule
